FILE: design/utf8d_pkg.sv
// shared types and constants of the utf-8 stream decoder
package utf8d_pkg;

  localparam int unsigned CpWidth    = 21;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CpWidth-1:0] ReplacementCp = 21'h00FFFD;

  // one decoded byte: up to four results, all but the last are replacements
  typedef struct packed {
    logic [1:0]         last_idx;
    logic [CpWidth-1:0] code_point;
    logic               is_replacement;
    logic               end_of_text;
  } entry_t;

endpackage

FILE: design/utf8d_front.sv
// front end: sequence state and byte classification into result entries
module utf8d_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        text_byte_i,
  output logic              entry_valid_o,
  output utf8d_pkg::entry_t entry_o
);

  logic [7:0] lead_q, lead_d;
  logic [1:0] exp_q, exp_d;
  logic [1:0] rcv_q, rcv_d;
  logic [7:0] cont_q [2];
  logic       cont_we;

  logic       pending, is_cont;
  logic [1:0] nrep;
  logic       tail;
  logic [2:0] count;
  logic [utf8d_pkg::CpWidth-1:0] tail_cp, seq_cp;
  logic       tail_rep, tail_end;

  assign pending = (exp_q != 2'd0);
  assign is_cont = (text_byte_i[7:6] == 2'b10);

  always_comb begin
    unique case (exp_q)
      2'd1:    seq_cp = {10'd0, lead_q[4:0], text_byte_i[5:0]};
      2'd2:    seq_cp = {5'd0, lead_q[3:0], cont_q[0][5:0], text_byte_i[5:0]};
      default: seq_cp = {lead_q[2:0], cont_q[0][5:0], cont_q[1][5:0], text_byte_i[5:0]};
    endcase
  end

  always_comb begin
    lead_d   = lead_q;
    exp_d    = exp_q;
    rcv_d    = rcv_q;
    cont_we  = 1'b0;
    nrep     = 2'd0;
    tail     = 1'b0;
    tail_cp  = utf8d_pkg::ReplacementCp;
    tail_rep = 1'b1;
    tail_end = 1'b0;
    if (pending && is_cont) begin
      if ({1'b0, rcv_q} + 3'd1 >= {1'b0, exp_q}) begin
        tail     = 1'b1;
        tail_cp  = seq_cp;
        tail_rep = 1'b0;
        lead_d   = 8'd0;
        exp_d    = 2'd0;
        rcv_d    = 2'd0;
      end else begin
        cont_we = 1'b1;
        rcv_d   = rcv_q + 2'd1;
      end
    end else begin
      if (pending) begin
        // broken sequence: lead plus each buffered continuation byte
        nrep   = (rcv_q >= 2'd2) ? 2'd3 : rcv_q + 2'd1;
        lead_d = 8'd0;
        exp_d  = 2'd0;
        rcv_d  = 2'd0;
      end
      priority if (text_byte_i == 8'd0) begin
        tail     = 1'b1;
        tail_cp  = '0;
        tail_rep = 1'b0;
        tail_end = 1'b1;
      end else if (!text_byte_i[7]) begin
        tail     = 1'b1;
        tail_cp  = {13'd0, text_byte_i};
        tail_rep = 1'b0;
      end else if (text_byte_i[7:5] == 3'b110) begin
        lead_d = text_byte_i;
        exp_d  = 2'd1;
      end else if (text_byte_i[7:4] == 4'b1110) begin
        lead_d = text_byte_i;
        exp_d  = 2'd2;
      end else if (text_byte_i[7:3] == 5'b11110) begin
        lead_d = text_byte_i;
        exp_d  = 2'd3;
      end else begin
        tail = 1'b1;
      end
    end
  end

  assign count         = {1'b0, nrep} + {2'd0, tail};
  assign entry_valid_o = accept_i && (count != 3'd0);
  assign entry_o.last_idx       = 2'(count - 3'd1);
  assign entry_o.code_point     = tail ? tail_cp : utf8d_pkg::ReplacementCp;
  assign entry_o.is_replacement = tail ? tail_rep : 1'b1;
  assign entry_o.end_of_text    = tail && tail_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= 8'd0;
      exp_q  <= 2'd0;
      rcv_q  <= 2'd0;
    end else if (accept_i) begin
      lead_q <= lead_d;
      exp_q  <= exp_d;
      rcv_q  <= rcv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && cont_we) begin
      cont_q[rcv_q[0]] <= text_byte_i;
    end
  end

endmodule

FILE: design/utf8d_fifo.sv
// short entry queue between front and back
module utf8d_fifo #(
  parameter int unsigned Depth = utf8d_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  utf8d_pkg::entry_t wr_data_i,
  output logic              full_o,
  input  logic              rd_en_i,
  output logic              valid_o,
  output utf8d_pkg::entry_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  utf8d_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: design/utf8d_back.sv
// back end: expands entries into single results behind an output register
module utf8d_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          entry_valid_i,
  input  utf8d_pkg::entry_t             entry_i,
  output logic                          entry_pop_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [utf8d_pkg::CpWidth-1:0] code_point_o,
  output logic                          is_replacement_o,
  output logic                          end_of_text_o,
  output logic                          last_of_run_o
);

  logic       out_valid_q;
  logic [1:0] idx_q;
  logic       load, is_last;
  logic [utf8d_pkg::CpWidth-1:0] cp_q;
  logic       rep_q, end_q, last_q;

  assign load        = entry_valid_i && (!out_valid_q || pop_i);
  assign is_last     = (idx_q == entry_i.last_idx);
  assign entry_pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= is_last ? entry_i.code_point : utf8d_pkg::ReplacementCp;
      rep_q  <= is_last ? entry_i.is_replacement : 1'b1;
      end_q  <= is_last && entry_i.end_of_text;
      last_q <= is_last;
    end
  end

  assign empty_o          = !out_valid_q;
  assign code_point_o     = cp_q;
  assign is_replacement_o = rep_q;
  assign end_of_text_o    = end_q;
  assign last_of_run_o    = last_q;

endmodule

FILE: design/utf8_stream_decoder_top.sv
// utf-8 stream decoder top level
// a result reaches the ports through the entry queue and the back-end output register
// throughput: one byte per cycle while each byte yields at most one result and results are popped as they appear
// a byte that yields k results holds them in the back-end output register one after another
// the entry queue (QDepth entries) lets the front keep taking bytes meanwhile
// reset: async, clears sequence state, queue pointers and output valid
module utf8_stream_decoder_top #(
  parameter int unsigned QDepth = utf8d_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    text_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [utf8d_pkg::CpWidth-1:0] code_point_o,
  output logic                          is_replacement_o,
  output logic                          end_of_text_o,
  output logic                          last_of_run_o
);

  logic              accept;
  logic              fe_valid, q_valid, q_pop;
  utf8d_pkg::entry_t fe_entry, q_entry;

  assign accept = push && !full;

  utf8d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .text_byte_i  (text_byte_i),
    .entry_valid_o(fe_valid),
    .entry_o      (fe_entry)
  );

  utf8d_fifo #(
    .Depth(QDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (fe_valid),
    .wr_data_i(fe_entry),
    .full_o   (full),
    .rd_en_i  (q_pop),
    .valid_o  (q_valid),
    .rd_data_o(q_entry)
  );

  utf8d_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entry_valid_i   (q_valid),
    .entry_i         (q_entry),
    .entry_pop_o     (q_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .code_point_o    (code_point_o),
    .is_replacement_o(is_replacement_o),
    .end_of_text_o   (end_of_text_o),
    .last_of_run_o   (last_of_run_o)
  );

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && end_of_text_o) |-> (last_of_run_o && code_point_o == '0))
    else $error("end of text result not final or nonzero");

  a_rep_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && is_replacement_o) |-> (code_point_o == utf8d_pkg::ReplacementCp))
    else $error("replacement flag with wrong code point");

  a_not_last_is_rep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_of_run_o) |-> is_replacement_o)
    else $error("non-final result is not a replacement");

  a_entry_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("entry taken from empty queue");

endmodule

FILE: dv/utf8_stream_decoder_checker.sv
// checker for the utf-8 stream decoder: predicts decoded code points and compares results
module utf8_stream_decoder_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic                          full_i,
  input  logic [7:0]                    text_byte_i,
  input  logic                          empty_i,
  input  logic                          pop_i,
  input  logic [utf8d_pkg::CpWidth-1:0] code_point_i,
  input  logic                          is_replacement_i,
  input  logic                          end_of_text_i,
  input  logic                          last_of_run_i,
  output int                            pending_o,
  output int                            fail_count_o
);

  typedef struct packed {
    logic [utf8d_pkg::CpWidth-1:0] cp;
    logic                          rep;
    logic                          eot;
    logic                          last;
  } decoded_t;

  logic [7:0] seq_lead;
  logic [7:0] cont_buf [2];
  logic [1:0] seq_len;
  logic [1:0] seq_got;
  decoded_t   decoded_q [$];
  int         errors = 0;

  assign fail_count_o = errors;

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("[%0t] %s: expected %0h got %0h", $time, what, want, got);
    errors++;
  endtask

  task automatic clear_seq();
    seq_lead = '0;
    seq_len  = '0;
    seq_got  = '0;
  endtask

  task automatic predict_byte(input logic [7:0] b);
    logic [utf8d_pkg::CpWidth-1:0] cp;
    logic [utf8d_pkg::CpWidth-1:0] res_cp  [4];
    logic                          res_rep [4];
    logic                          res_eot [4];
    int                            n;
    n = 0;
    if (seq_len != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        if (int'(seq_got) + 1 >= int'(seq_len)) begin
          case (seq_len)
            2'd1:    cp = {10'd0, seq_lead[4:0], b[5:0]};
            2'd2:    cp = {5'd0, seq_lead[3:0], cont_buf[0][5:0], b[5:0]};
            default: cp = {seq_lead[2:0], cont_buf[0][5:0], cont_buf[1][5:0], b[5:0]};
          endcase
          clear_seq();
          decoded_q.push_back('{cp: cp, rep: 1'b0, eot: 1'b0, last: 1'b1});
          return;
        end
        cont_buf[seq_got[0]] = b;
        seq_got = seq_got + 2'd1;
        return;
      end
      // broken sequence: one replacement for the lead and each buffered byte
      for (int i = 0; i <= int'(seq_got) && i < 3; i++) begin
        res_cp[n] = utf8d_pkg::ReplacementCp; res_rep[n] = 1'b1; res_eot[n] = 1'b0; n++;
      end
      clear_seq();
    end
    if (b == 8'h00) begin
      clear_seq();
      cont_buf[0] = '0;
      cont_buf[1] = '0;
      res_cp[n] = '0; res_rep[n] = 1'b0; res_eot[n] = 1'b1; n++;
    end else if (!b[7]) begin
      res_cp[n] = {13'd0, b}; res_rep[n] = 1'b0; res_eot[n] = 1'b0; n++;
    end else if (b[7:5] == 3'b110) begin
      seq_lead = b; seq_len = 2'd1; seq_got = 2'd0;
    end else if (b[7:4] == 4'b1110) begin
      seq_lead = b; seq_len = 2'd2; seq_got = 2'd0;
    end else if (b[7:3] == 5'b11110) begin
      seq_lead = b; seq_len = 2'd3; seq_got = 2'd0;
    end else begin
      res_cp[n] = utf8d_pkg::ReplacementCp; res_rep[n] = 1'b1; res_eot[n] = 1'b0; n++;
    end
    for (int i = 0; i < n; i++) begin
      decoded_q.push_back('{cp: res_cp[i], rep: res_rep[i], eot: res_eot[i], last: (i == n - 1)});
    end
  endtask

  task automatic check_result();
    decoded_t want;
    if (decoded_q.size() == 0) begin
      report("unexpected result, code_point", '0, 32'(code_point_i));
      return;
    end
    want = decoded_q.pop_front();
    if (code_point_i !== want.cp)
      report("code_point", 32'(want.cp), 32'(code_point_i));
    if (is_replacement_i !== want.rep)
      report("is_replacement", 32'(want.rep), 32'(is_replacement_i));
    if (end_of_text_i !== want.eot)
      report("end_of_text", 32'(want.eot), 32'(end_of_text_i));
    if (last_of_run_i !== want.last)
      report("last_of_run", 32'(want.last), 32'(last_of_run_i));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_seq();
      cont_buf[0] = '0;
      cont_buf[1] = '0;
      decoded_q.delete();
      pending_o <= 0;
    end else begin
      if (pop_i && !empty_i) check_result();
      if (push_i && !full_i) predict_byte(text_byte_i);
      pending_o <= decoded_q.size();
    end
  end

endmodule

FILE: dv/utf8_stream_decoder_top_tb.sv
// testbench top for the utf-8 stream decoder: byte stimulus, result draining and verdict
module utf8_stream_decoder_top_tb;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 20;
  localparam int TotalBytes    = 310;

  logic                          clk_i;
  logic                          rst_ni      = 1'b0;
  logic                          push        = 1'b0;
  logic                          full;
  logic [7:0]                    text_byte_i = 8'h00;
  logic                          empty;
  logic                          pop         = 1'b0;
  logic [utf8d_pkg::CpWidth-1:0] code_point_o;
  logic                          is_replacement_o;
  logic                          end_of_text_o;
  logic                          last_of_run_o;

  int pending;
  int fail_count;
  int bytes_sent = 0;
  int idle_cycles = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  utf8_stream_decoder_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .text_byte_i      (text_byte_i),
    .empty            (empty),
    .pop              (pop),
    .code_point_o     (code_point_o),
    .is_replacement_o (is_replacement_o),
    .end_of_text_o    (end_of_text_o),
    .last_of_run_o    (last_of_run_o)
  );

  utf8_stream_decoder_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_i           (full),
    .text_byte_i      (text_byte_i),
    .empty_i          (empty),
    .pop_i            (pop),
    .code_point_i     (code_point_o),
    .is_replacement_i (is_replacement_o),
    .end_of_text_i    (end_of_text_o),
    .last_of_run_i    (last_of_run_o),
    .pending_o        (pending),
    .fail_count_o     (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] lead_byte_of(int len);
    case (len)
      2:       return 8'($urandom_range(8'hC0, 8'hDF));
      3:       return 8'($urandom_range(8'hE0, 8'hEF));
      default: return 8'($urandom_range(8'hF0, 8'hF7));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int g;
    g = pick_gap(tx_calm);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push        <= 1'b1;
    text_byte_i <= b;
    do @(posedge clk_i); while (full);
    bytes_sent++;
    if (bytes_sent % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic wait_all_decoded();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic send_random_burst();
    logic [7:0] burst [$];
    logic [7:0] t;
    int         kind;
    int         len;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      len = $urandom_range(1, 4);
      if (len == 1) burst.push_back(8'($urandom_range(1, 127)));
      else begin
        burst.push_back(lead_byte_of(len));
        repeat (len - 1) burst.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end
    end else if (kind < 60) begin
      if ($urandom_range(0, 99) < 8) burst.push_back(8'h00);
      else burst.push_back(8'($urandom_range(1, 127)));
    end else if (kind < 80) begin
      len = $urandom_range(2, 4);
      burst.push_back(lead_byte_of(len));
      repeat ($urandom_range(0, len - 2)) burst.push_back(8'($urandom_range(8'h80, 8'hBF)));
      if ($urandom_range(0, 99) < 15) t = 8'h00;
      else do t = 8'($urandom_range(0, 255)); while (t[7:6] == 2'b10);
      burst.push_back(t);
    end else begin
      burst.push_back(8'($urandom_range(0, 255)));
    end
    foreach (burst[i]) send_byte(burst[i]);
  endtask

  initial begin
    logic [7:0] directed [] = '{
      8'h00, 8'h41, 8'h7F, 8'hC2, 8'hA9, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h80,
      8'hF8, 8'hFF, 8'hF0, 8'h90, 8'h80, 8'h41, 8'hE2, 8'h00, 8'hC3, 8'hC3,
      8'hA9, 8'hEF, 8'hBF, 8'hBD
    };
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_byte(directed[i]);
    wait_all_decoded();
    while (bytes_sent < TotalBytes) begin
      send_random_burst();
      if ($urandom_range(0, 99) < 3) wait_all_decoded();
    end
    wait_all_decoded();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int g;
    int n;
    n = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      g = pick_gap(rx_calm);
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      n++;
      if (n % 30 == 0) rx_calm = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
